### sv/ntc_a2t_pkg.sv
`timescale 1ns / 1ps

package ntc_a2t_pkg;

  // table geometry
  localparam int unsigned TABLE_ENTRIES = 98;
  localparam int unsigned TBL_AW        = $clog2(TABLE_ENTRIES);
  localparam int unsigned ENTRY_W       = 16;
  localparam int unsigned INDEX_W       = 7;
  localparam int unsigned ADC_W         = 12;
  localparam int unsigned TEMP_OUT_W    = 10;

  // resistance code = floor(CODE_NUM_K*a / (CODE_DEN_BASE - CODE_DEN_K*a))
  localparam int unsigned CODE_NUM_K    = 330000;
  localparam int unsigned CODE_DEN_BASE = 204800;
  localparam int unsigned CODE_DEN_K    = 33;

  // shared divider sizes
  localparam int unsigned DIV_NW  = 31;
  localparam int unsigned DIV_DW  = 18;
  localparam int unsigned DIV_CW  = $clog2(DIV_NW);

  // x/10 for a 16-bit x as (x * DIV10_MUL) >> DIV10_SHIFT
  localparam int unsigned DIV10_MUL   = 52429;
  localparam int unsigned DIV10_SHIFT = 19;
  localparam int unsigned STEP_W      = 2 * ENTRY_W - DIV10_SHIFT;

  localparam int unsigned FRAC_MAX  = 10;
  localparam int unsigned FRAC_W    = 4;
  localparam int unsigned TEMP_MAX  = 1023;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BELOW     = 2'd1,
    ST_BEYOND    = 2'd2,
    ST_ZERO_STEP = 2'd3
  } status_e;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

endpackage

### sv/ntc_a2t_ram.sv
`timescale 1ns / 1ps

module ntc_a2t_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 98
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/ntc_a2t_div.sv
`timescale 1ns / 1ps

module ntc_a2t_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ntc_a2t_pkg::div_req_t req_i,
  output ntc_a2t_pkg::div_rsp_t rsp_o
);
  import ntc_a2t_pkg::*;

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_DW-1:0] rem_q, rem_d;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW-1:0] dsr_q, dsr_d;
  logic [DIV_DW:0]   trial;
  logic              ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[DIV_NW-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = DIV_CW'(DIV_NW - 1);
      rem_d = '0;
      quo_d = req_i.dividend;
      dsr_d = req_i.divisor;
    end else if (run_q) begin
      rem_d = ge ? DIV_DW'(trial - {1'b0, dsr_q}) : DIV_DW'(trial);
      quo_d = {quo_q[DIV_NW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### sv/ntc_adc_to_temperature.sv
`timescale 1ns / 1ps
// loads: a load is written in the cycle it is taken and busy stays low
// a conversion uses the shared divider for the resistance code, then checks both
// table ends; inside the table it binary-searches and may divide for the fraction
// one conversion at a time: busy is high from acceptance until the result strobe
// results are strobed for one cycle on valid_o; the receiver cannot stall
// async active-low reset returns to idle; table contents are undefined until loaded
module ntc_adc_to_temperature (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation_i,
  input  logic [ntc_a2t_pkg::INDEX_W-1:0]     entry_index_i,
  input  logic [ntc_a2t_pkg::ENTRY_W-1:0]     entry_value_i,
  input  logic [ntc_a2t_pkg::ADC_W-1:0]       adc_sample_i,
  output logic                                valid_o,
  output logic [ntc_a2t_pkg::TEMP_OUT_W-1:0]  temperature_tenths_o,
  output logic [1:0]                          status_o
);
  import ntc_a2t_pkg::*;

  localparam int unsigned TEMP_W = TBL_AW + 4;
  localparam int unsigned PROD_W = DIV_NW;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_MUL       = 11'b000_0000_0010,
    S_CODE_GO   = 11'b000_0000_0100,
    S_CODE_WAIT = 11'b000_0000_1000,
    S_CHK0      = 11'b000_0001_0000,
    S_CHKN      = 11'b000_0010_0000,
    S_SRCH      = 11'b000_0100_0000,
    S_TOP       = 11'b000_1000_0000,
    S_BOT       = 11'b001_0000_0000,
    S_STEP      = 11'b010_0000_0000,
    S_FRAC_WAIT = 11'b100_0000_0000
  } state_e;

  localparam logic [TBL_AW-1:0] LAST_IDX = TBL_AW'(TABLE_ENTRIES - 1);
  localparam logic [TBL_AW-1:0] MID0     = TBL_AW'((TABLE_ENTRIES - 1) / 2);

  function automatic logic [TEMP_OUT_W-1:0] tenths(logic [TBL_AW-1:0] lo,
                                                   logic [FRAC_W-1:0] frac);
    logic [TEMP_W-1:0] t;
    t = TEMP_W'(lo) * TEMP_W'(10) + TEMP_W'(frac);
    return (t > TEMP_W'(TEMP_MAX)) ? TEMP_OUT_W'(TEMP_MAX) : TEMP_OUT_W'(t);
  endfunction

  state_e              state_q, state_d;
  logic                valid_q, valid_d;
  logic [ADC_W-1:0]    adc_q, adc_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [DIV_DW-1:0]   den_q, den_d;
  logic [ENTRY_W-1:0]  code_q, code_d;
  logic [TBL_AW-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [ENTRY_W-1:0]  top_q, top_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [TEMP_OUT_W-1:0] temp_q, temp_d;
  status_e             status_q, status_d;

  logic                ram_we;
  logic [TBL_AW-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                lt;
  logic [TBL_AW-1:0]   lo_n, hi_n, mid_n, gap;
  logic [TBL_AW:0]     sum_n;
  logic [ENTRY_W-1:0]  diff;
  logic [2*ENTRY_W-1:0] div10;
  logic [FRAC_W-1:0]   frac;

  assign busy = (state_q != S_IDLE);

  // loads go straight into the table
  assign ram_we = start && !busy && (operation_i == OP_LOAD)
                  && ({2'b00, entry_index_i} < 9'(TABLE_ENTRIES));

  ntc_a2t_ram #(
    .Width(ENTRY_W),
    .Depth(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(TBL_AW'(entry_index_i)),
    .wdata_i(entry_value_i),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ntc_a2t_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // one search step on the entry at mid
  assign lt    = ram_rdata < code_q;
  assign lo_n  = lt ? lo_q : mid_q;
  assign hi_n  = lt ? mid_q : hi_q;
  assign gap   = hi_n - lo_n;
  assign sum_n = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n = sum_n[TBL_AW:1];

  assign diff  = top_q - ram_rdata;
  assign div10 = (2*ENTRY_W)'(diff) * (2*ENTRY_W)'(DIV10_MUL);
  assign frac  = (div_rsp.quotient > DIV_NW'(FRAC_MAX)) ? FRAC_W'(FRAC_MAX)
                                                       : div_rsp.quotient[FRAC_W-1:0];

  always_comb begin
    state_d   = state_q;
    valid_d   = 1'b0;
    adc_d     = adc_q;
    prod_d    = prod_q;
    den_d     = den_q;
    code_d    = code_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    top_d     = top_q;
    step_d    = step_q;
    temp_d    = temp_q;
    status_d  = status_q;
    ram_raddr = '0;
    div_req   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start && (operation_i == OP_CONVERT)) begin
          adc_d   = adc_sample_i;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = PROD_W'(CODE_NUM_K) * PROD_W'(adc_q);
        den_d   = DIV_DW'(CODE_DEN_BASE) - DIV_DW'(CODE_DEN_K) * DIV_DW'(adc_q);
        state_d = S_CODE_GO;
      end
      S_CODE_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = den_q;
        state_d          = S_CODE_WAIT;
      end
      S_CODE_WAIT: begin
        ram_raddr = '0;
        if (div_rsp.done) begin
          code_d  = div_rsp.quotient[ENTRY_W-1:0];
          state_d = S_CHK0;
        end
      end
      S_CHK0: begin
        if (code_q > ram_rdata) begin
          temp_d   = '0;
          status_d = ST_BELOW;
          valid_d  = 1'b1;
          state_d  = S_IDLE;
        end else begin
          ram_raddr = LAST_IDX;
          state_d   = S_CHKN;
        end
      end
      S_CHKN: begin
        if (code_q < ram_rdata) begin
          temp_d   = tenths(LAST_IDX, '0);
          status_d = ST_BEYOND;
          valid_d  = 1'b1;
          state_d  = S_IDLE;
        end else begin
          lo_d      = '0;
          hi_d      = LAST_IDX;
          mid_d     = MID0;
          ram_raddr = MID0;
          state_d   = S_SRCH;
        end
      end
      S_SRCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (gap > TBL_AW'(1)) begin
          mid_d     = mid_n;
          ram_raddr = mid_n;
        end else if (gap == '0) begin
          // collapsed bracket
          temp_d   = tenths(lo_n, '0);
          status_d = ST_OK;
          valid_d  = 1'b1;
          state_d  = S_IDLE;
        end else begin
          ram_raddr = lo_n;
          state_d   = S_TOP;
        end
      end
      S_TOP: begin
        top_d     = ram_rdata;
        ram_raddr = hi_q;
        state_d   = S_BOT;
      end
      S_BOT: begin
        // rdata holds the entry at hi, the lower value of the bracket
        step_d  = (top_q >= ram_rdata) ? div10[2*ENTRY_W-1:DIV10_SHIFT] : '0;
        state_d = S_STEP;
      end
      S_STEP: begin
        if (step_q == '0) begin
          temp_d   = tenths(lo_q, '0);
          status_d = ST_ZERO_STEP;
          valid_d  = 1'b1;
          state_d  = S_IDLE;
        end else if (top_q > code_q) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_NW'(top_q - code_q);
          div_req.divisor  = DIV_DW'(step_q);
          state_d          = S_FRAC_WAIT;
        end else begin
          temp_d   = tenths(lo_q, '0);
          status_d = ST_OK;
          valid_d  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_FRAC_WAIT: begin
        if (div_rsp.done) begin
          temp_d   = tenths(lo_q, frac);
          status_d = ST_OK;
          valid_d  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    adc_q    <= adc_d;
    prod_q   <= prod_d;
    den_q    <= den_d;
    code_q   <= code_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    top_q    <= top_d;
    step_q   <= step_d;
    temp_q   <= temp_d;
    status_q <= status_d;
  end

  assign valid_o              = valid_q;
  assign temperature_tenths_o = temp_q;
  assign status_o             = status_q;

endmodule
